// File: rtl/swr_pkg.sv
`timescale 1ns / 1ps

package swr_pkg;

   // field widths
   localparam int FRAME_W = 10;
   localparam int SEQ_W   = 32;
   localparam int TAG_W   = 16;
   localparam int BYTES_W = 9;
   localparam int WIN_W   = 6;

   // default slot count of the receive window
   localparam int MAX_WINDOW_DEF = 32;

   // header length codes and limits
   localparam logic [FRAME_W-1:0] LEN_ACK     = 10'd8;
   localparam logic [FRAME_W-1:0] LEN_EOS     = 10'd12;
   localparam logic [BYTES_W-1:0] PAYLOAD_MAX = 9'd500;
   localparam logic [WIN_W-1:0]   WINDOW_RESET = 6'd8;

   // operations of the shared sequence adder
   localparam logic ADD_OP_ADD = 1'b0;
   localparam logic ADD_OP_SUB = 1'b1;

   // one held slot entry
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [FRAME_W-1:0] length;
   } slot_type;

   // data bytes carried by a frame of the given header length
   function automatic logic [BYTES_W-1:0] data_bytes(input logic [FRAME_W-1:0] len);
      logic [FRAME_W-1:0] rem;
      rem = len - LEN_EOS;
      if (len < LEN_EOS) begin
         return '0;
      end else if (rem > {1'b0, PAYLOAD_MAX}) begin
         return PAYLOAD_MAX;
      end else begin
         return rem[BYTES_W-1:0];
      end
   endfunction

endpackage

// File: rtl/swr_req_if.sv
`timescale 1ns / 1ps

interface swr_req_if;
   import swr_pkg::*;

   logic               valid;
   logic               ready;
   logic [FRAME_W-1:0] frame_bytes;
   logic [FRAME_W-1:0] header_length;
   logic               checksum_ok;
   logic [SEQ_W-1:0]   seqno;
   logic [TAG_W-1:0]   payload_tag;
   logic               output_ready;

   modport source (
      output valid, frame_bytes, header_length, checksum_ok, seqno, payload_tag,
             output_ready,
      input  ready
   );

   modport sink (
      input  valid, frame_bytes, header_length, checksum_ok, seqno, payload_tag,
             output_ready,
      output ready
   );

endinterface

// File: rtl/swr_rsp_if.sv
`timescale 1ns / 1ps

interface swr_rsp_if;
   import swr_pkg::*;

   logic               valid;
   logic               ready;
   logic               delivered;
   logic               end_of_stream;
   logic [TAG_W-1:0]   out_payload_tag;
   logic [BYTES_W-1:0] payload_bytes;
   logic [SEQ_W-1:0]   ack_number;
   logic               last;

   modport source (
      output valid, delivered, end_of_stream, out_payload_tag, payload_bytes,
             ack_number, last,
      input  ready
   );

   modport sink (
      input  valid, delivered, end_of_stream, out_payload_tag, payload_bytes,
             ack_number, last,
      output ready
   );

endinterface

// File: rtl/sliding_window_receiver.sv
`timescale 1ns / 1ps
// Receive side of a sliding-window link with cumulative acknowledgement.
// req_chan carries one arriving frame per item: lengths, checksum verdict,
// sequence number, payload handle and whether the consumer can take data.
// rsp_chan carries the results: a delivered frame with its new ack number,
// or an ack-only repeat for a stale frame; last marks the final result of
// an item. csr_write_enable/csr_write_data set the window size; the user must write
// them only while the block is idle, and the block itself does not enforce this.
// Timing: an item is taken in one cycle and classified in the next, so an
// item with no result frees the input once it is classified. Each result
// passes through slot check, registered memory read and output hand-off;
// an ack-only result goes from classification straight to the hand-off.
// The shared 33-bit sequence adder and the single slot memory read port
// shape this sequence. req_chan.ready is low while an item is being handled.
// If rsp_chan.ready is low the result register holds and the block waits.
// Reset (synchronous) empties the window, sets the expected number to 1
// and the window size to 8; no clearing pass is needed.
module sliding_window_receiver #(
   parameter int MAX_WINDOW = swr_pkg::MAX_WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [swr_pkg::WIN_W-1:0] csr_write_data,
   swr_req_if.sink                   req_chan,
   swr_rsp_if.source                 rsp_chan
);
   import swr_pkg::*;

   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam logic [CW-1:0] M_C       = CW'(MAX_WINDOW);
   localparam logic [IW-1:0] IDX_LAST  = IW'(MAX_WINDOW - 1);
   localparam logic [IW-1:0] IDX_RESET = IW'(1 % MAX_WINDOW);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EVAL     = 3'd1;
   localparam logic [2:0] S_READ     = 3'd2;
   localparam logic [2:0] S_DELIVER  = 3'd3;
   localparam logic [2:0] S_OUT_WAIT = 3'd4;

   // control registers
   logic [2:0]            state_ff, state_in;
   logic [WIN_W-1:0]      window_size_ff, window_size_in;
   logic [SEQ_W-1:0]      expected_ff, expected_in;
   logic [IW-1:0]         exp_idx_ff, exp_idx_in;
   logic [CW-1:0]         held_count_ff, held_count_in;
   logic [MAX_WINDOW-1:0] slot_valid_ff, slot_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // item and result payload registers
   logic [FRAME_W-1:0] fbytes_ff, hlen_ff;
   logic               ck_ff, oready_ff;
   logic [SEQ_W-1:0]   seq_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic               rsp_dlv_ff, rsp_dlv_in;
   logic               rsp_eos_ff, rsp_eos_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [SEQ_W-1:0]   rsp_ack_ff, rsp_ack_in;
   logic               rsp_last_ff, rsp_last_in;

   // shared adder and slot memory
   logic               add_op;
   logic [SEQ_W-1:0]   add_a, add_b;
   logic [SEQ_W:0]     add_sum;
   logic               mem_we;
   logic [IW-1:0]      new_idx;
   slot_type           mem_wdata, mem_rdata;

   // decode
   logic [CW-1:0]         win;
   logic                  frame_bad, is_old, in_window, full;
   logic [CW:0]           idx_sum;
   logic [SEQ_W-1:0]      exp_next;
   logic [IW-1:0]         idx_next;
   logic [MAX_WINDOW-1:0] valid_clr;
   logic                  req_fire, rsp_fire;

   swr_seq_adder u_adder (
      .op  (add_op),
      .a   (add_a),
      .b   (add_b),
      .sum (add_sum)
   );

   swr_slot_mem #(
      .DEPTH (MAX_WINDOW),
      .IW    (IW)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (new_idx),
      .wr_data (mem_wdata),
      .rd_addr (exp_idx_ff),
      .rd_data (mem_rdata)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // window span clamped to the slot count
   assign win = ({1'b0, window_size_ff} > 7'(MAX_WINDOW)) ? M_C : CW'(window_size_ff);

   // adder: offset from expected while classifying, increment while delivering
   always_comb begin
      if (state_ff == S_EVAL) begin
         add_op = ADD_OP_SUB;
         add_a  = seq_ff;
         add_b  = expected_ff;
      end else begin
         add_op = ADD_OP_ADD;
         add_a  = expected_ff;
         add_b  = SEQ_W'(1);
      end
   end

   // classification of the held item
   always_comb begin
      frame_bad = (hlen_ff != fbytes_ff) || !ck_ff || (hlen_ff == LEN_ACK);
      is_old    = add_sum[SEQ_W];
      in_window = !is_old && ((add_sum[SEQ_W-1:0] >> CW) == '0)
                  && (add_sum[CW-1:0] < win);
      full      = (held_count_ff >= win);
      idx_sum   = {1'b0, CW'(exp_idx_ff)} + {1'b0, add_sum[CW-1:0]};
      if (idx_sum >= {1'b0, M_C}) begin
         idx_sum = idx_sum - {1'b0, M_C};
      end
      new_idx   = idx_sum[IW-1:0];
   end

   // next expected number and slot index
   always_comb begin
      exp_next = add_sum[SEQ_W-1:0];
      if (exp_next == '0) begin
         idx_next = '0;
      end else if (exp_idx_ff == IDX_LAST) begin
         idx_next = '0;
      end else begin
         idx_next = exp_idx_ff + IW'(1);
      end
      valid_clr = slot_valid_ff & ~(MAX_WINDOW'(1) << exp_idx_ff);
   end

   assign mem_wdata = '{tag: tag_ff, length: hlen_ff};

   // sequencer
   always_comb begin
      state_in       = state_ff;
      window_size_in = csr_write_enable ? csr_write_data : window_size_ff;
      expected_in    = expected_ff;
      exp_idx_in     = exp_idx_ff;
      held_count_in  = held_count_ff;
      slot_valid_in  = slot_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_dlv_in     = rsp_dlv_ff;
      rsp_eos_in     = rsp_eos_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_ack_in     = rsp_ack_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            priority if (frame_bad) begin
               state_in = S_IDLE;
            end else if (is_old) begin
               if (seq_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  // stale frame: repeat the cumulative ack
                  rsp_valid_in = 1'b1;
                  rsp_dlv_in   = 1'b0;
                  rsp_eos_in   = 1'b0;
                  rsp_tag_in   = '0;
                  rsp_bytes_in = '0;
                  rsp_ack_in   = expected_ff;
                  rsp_last_in  = 1'b1;
                  state_in     = S_OUT_WAIT;
               end
            end else if (full || !in_window || slot_valid_ff[new_idx]) begin
               state_in = S_IDLE;
            end else begin
               // hold the frame
               mem_we                 = 1'b1;
               slot_valid_in[new_idx] = 1'b1;
               held_count_in          = held_count_ff + CW'(1);
               state_in               = oready_ff ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            state_in = slot_valid_ff[exp_idx_ff] ? S_DELIVER : S_IDLE;
         end
         S_DELIVER: begin
            rsp_valid_in  = 1'b1;
            rsp_dlv_in    = 1'b1;
            rsp_eos_in    = (mem_rdata.length == LEN_EOS);
            rsp_tag_in    = mem_rdata.tag;
            rsp_bytes_in  = data_bytes(mem_rdata.length);
            rsp_ack_in    = exp_next;
            rsp_last_in   = !valid_clr[idx_next];
            slot_valid_in = valid_clr;
            if (held_count_ff != '0) begin
               held_count_in = held_count_ff - CW'(1);
            end
            expected_in   = exp_next;
            exp_idx_in    = idx_next;
            state_in      = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               state_in     = rsp_last_ff ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         window_size_ff <= WINDOW_RESET;
         expected_ff    <= SEQ_W'(1);
         exp_idx_ff     <= IDX_RESET;
         held_count_ff  <= '0;
         slot_valid_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         window_size_ff <= window_size_in;
         expected_ff    <= expected_in;
         exp_idx_ff     <= exp_idx_in;
         held_count_ff  <= held_count_in;
         slot_valid_ff  <= slot_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // item capture and result payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         fbytes_ff <= req_chan.frame_bytes;
         hlen_ff   <= req_chan.header_length;
         ck_ff     <= req_chan.checksum_ok;
         seq_ff    <= req_chan.seqno;
         tag_ff    <= req_chan.payload_tag;
         oready_ff <= req_chan.output_ready;
      end
      rsp_dlv_ff   <= rsp_dlv_in;
      rsp_eos_ff   <= rsp_eos_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_ack_ff   <= rsp_ack_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.delivered       = rsp_dlv_ff;
   assign rsp_chan.end_of_stream   = rsp_eos_ff;
   assign rsp_chan.out_payload_tag = rsp_tag_ff;
   assign rsp_chan.payload_bytes   = rsp_bytes_ff;
   assign rsp_chan.ack_number      = rsp_ack_ff;
   assign rsp_chan.last            = rsp_last_ff;

   // a result is only offered from the hand-off state
   a_rsp_state : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT_WAIT))
      else $error("result offered outside hand-off state");

   // held count tracks the slot valid bits
   a_held_count : assert property (@(posedge clock) disable iff (reset)
      $countones(slot_valid_ff) == int'(held_count_ff))
      else $error("held count out of step with slot valid bits");

   // the final result of an item releases the input
   a_last_idle : assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_ff) |=> (state_ff == S_IDLE))
      else $error("block not idle after final result");

   // never take an item while a result is pending
   a_no_overlap : assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !rsp_valid_ff)
      else $error("input ready while a result is pending");

endmodule

// File: rtl/swr_seq_adder.sv
`timescale 1ns / 1ps

module swr_seq_adder (
   input  logic                    op,
   input  logic [swr_pkg::SEQ_W-1:0] a,
   input  logic [swr_pkg::SEQ_W-1:0] b,
   output logic [swr_pkg::SEQ_W:0]   sum
);
   import swr_pkg::*;

   // 33-bit add or subtract, top bit is carry or borrow
   always_comb begin
      if (op == ADD_OP_SUB) begin
         sum = {1'b0, a} - {1'b0, b};
      end else begin
         sum = {1'b0, a} + {1'b0, b};
      end
   end

endmodule

// File: rtl/swr_slot_mem.sv
`timescale 1ns / 1ps

module swr_slot_mem #(
   parameter int DEPTH = swr_pkg::MAX_WINDOW_DEF,
   parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IW-1:0]     wr_addr,
   input  swr_pkg::slot_type wr_data,
   input  logic [IW-1:0]     rd_addr,
   output swr_pkg::slot_type rd_data
);
   import swr_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/sliding_window_receiver_test.sv
`timescale 1ns / 1ps

module sliding_window_receiver_test;
   import swr_pkg::*;

   localparam int MAX_WINDOW    = MAX_WINDOW_DEF;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_bytes;
      logic [FRAME_W-1:0] header_length;
      logic               checksum_ok;
      logic [SEQ_W-1:0]   seqno;
      logic [TAG_W-1:0]   payload_tag;
      logic               output_ready;
   } frame_type;

   typedef struct packed {
      logic               delivered;
      logic               end_of_stream;
      logic [TAG_W-1:0]   out_payload_tag;
      logic [BYTES_W-1:0] payload_bytes;
      logic [SEQ_W-1:0]   ack_number;
      logic               last;
   } delivery_type;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [WIN_W-1:0] csr_write_data;
   logic             no_idle;
   int               error_count;

   swr_req_if req_link ();
   swr_rsp_if rsp_link ();

   sliding_window_receiver i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_link),
      .rsp_chan         (rsp_link)
   );

   // receive window model
   logic [WIN_W-1:0]   window_reg;
   logic [SEQ_W-1:0]   next_seqno;
   logic               held_valid [MAX_WINDOW];
   logic [TAG_W-1:0]   held_tag [MAX_WINDOW];
   logic [FRAME_W-1:0] held_length [MAX_WINDOW];
   int                 held_count;
   delivery_type       expected_deliveries [$];

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // overall cycle limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("sliding_window_receiver_test: errors");
      $finish;
   end

   // result-side back-pressure
   initial begin
      rsp_link.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_link.ready <= no_idle || ($urandom_range(0, 99) >= 20);
      end
   end

   task automatic report_error(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // data bytes of a delivered frame, clipped at both ends
   function automatic logic [BYTES_W-1:0] payload_count(input logic [FRAME_W-1:0] len);
      if (len < LEN_EOS) return '0;
      if (len - LEN_EOS > PAYLOAD_MAX) return PAYLOAD_MAX;
      return BYTES_W'(len - LEN_EOS);
   endfunction

   // update the window model with one accepted frame, queue its results
   function automatic void predict_frame(input frame_type f);
      int                 span;
      int                 slot;
      int                 n;
      logic [SEQ_W:0]     upper;
      logic [FRAME_W-1:0] len;
      delivery_type       d;
      span = int'(window_reg);
      if (span > MAX_WINDOW) span = MAX_WINDOW;
      // bad lengths, bad checksum and ack frames are dropped
      if (f.header_length != f.frame_bytes || !f.checksum_ok || f.header_length == LEN_ACK)
         return;
      // stale frame repeats the cumulative ack, except number zero
      if (f.seqno < next_seqno) begin
         if (f.seqno != '0) begin
            d = '0;
            d.ack_number = next_seqno;
            d.last = 1'b1;
            expected_deliveries.push_back(d);
         end
         return;
      end
      // window full, beyond the span, or already held
      upper = {1'b0, next_seqno} + (SEQ_W+1)'(span);
      slot = f.seqno % MAX_WINDOW;
      if (held_count >= span || {1'b0, f.seqno} >= upper || held_valid[slot]) return;
      held_valid[slot] = 1'b1;
      held_tag[slot] = f.payload_tag;
      held_length[slot] = f.header_length;
      held_count++;
      if (!f.output_ready) return;
      // flush consecutive held frames from the expected number on
      n = 0;
      while (n < MAX_WINDOW && held_valid[next_seqno % MAX_WINDOW]) begin
         slot = next_seqno % MAX_WINDOW;
         len = held_length[slot];
         held_valid[slot] = 1'b0;
         held_count--;
         next_seqno++;
         n++;
         d.delivered = 1'b1;
         d.end_of_stream = (len == LEN_EOS);
         d.out_payload_tag = held_tag[slot];
         d.payload_bytes = payload_count(len);
         d.ack_number = next_seqno;
         d.last = (n == MAX_WINDOW) || !held_valid[next_seqno % MAX_WINDOW];
         expected_deliveries.push_back(d);
      end
   endfunction

   // well-formed frame with a random payload handle
   function automatic frame_type data_frame(input logic [SEQ_W-1:0] seq,
                                            input logic [FRAME_W-1:0] len,
                                            input logic ready);
      frame_type f;
      f.frame_bytes = len;
      f.header_length = len;
      f.checksum_ok = 1'b1;
      f.seqno = seq;
      f.payload_tag = TAG_W'($urandom_range(0, 65535));
      f.output_ready = ready;
      return f;
   endfunction

   function automatic logic [FRAME_W-1:0] random_length();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return LEN_EOS;
      if (pick == 1) return FRAME_W'($urandom_range(0, 11));
      if (pick == 2) return FRAME_W'($urandom_range(500, 1023));
      return FRAME_W'($urandom_range(13, 200));
   endfunction

   // send one item, with random gaps before it
   task automatic send_frame(input frame_type f);
      while (!no_idle && $urandom_range(0, 99) < 20) begin
         req_link.valid <= 1'b0;
         @(posedge clock);
      end
      req_link.valid <= 1'b1;
      req_link.frame_bytes <= f.frame_bytes;
      req_link.header_length <= f.header_length;
      req_link.checksum_ok <= f.checksum_ok;
      req_link.seqno <= f.seqno;
      req_link.payload_tag <= f.payload_tag;
      req_link.output_ready <= f.output_ready;
      @(posedge clock);
      while (!req_link.ready) @(posedge clock);
      predict_frame(f);
   endtask

   task automatic wait_results_done();
      req_link.valid <= 1'b0;
      @(posedge clock);
      while (expected_deliveries.size() != 0) @(posedge clock);
   endtask

   // window size is only changed once the block has gone quiet
   task automatic write_window(input logic [WIN_W-1:0] value);
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      window_reg = value;
   endtask

   task automatic test_in_order_delivery();
      send_frame(data_frame(next_seqno, 10'd20, 1'b1));
      send_frame(data_frame(next_seqno, LEN_EOS, 1'b1));
      // short lengths report no data bytes, long ones are clipped
      send_frame(data_frame(next_seqno, 10'd5, 1'b1));
      send_frame(data_frame(next_seqno, 10'd0, 1'b1));
      send_frame(data_frame(next_seqno, 10'd1023, 1'b1));
   endtask

   task automatic test_dropped_frames();
      frame_type f;
      f = data_frame(next_seqno, 10'd40, 1'b1);
      f.frame_bytes = 10'd41;
      send_frame(f);
      f = data_frame(next_seqno, 10'd40, 1'b1);
      f.checksum_ok = 1'b0;
      send_frame(f);
      send_frame(data_frame(next_seqno, LEN_ACK, 1'b1));
   endtask

   task automatic test_reordering();
      logic [SEQ_W-1:0] base;
      base = next_seqno;
      send_frame(data_frame(base + 2, 10'd30, 1'b1));
      send_frame(data_frame(base + 1, 10'd30, 1'b1));
      // held duplicate is ignored
      send_frame(data_frame(base + 1, 10'd30, 1'b1));
      // consumer not ready: held without flush
      send_frame(data_frame(base, 10'd30, 1'b0));
      send_frame(data_frame(base + 3, 10'd30, 1'b1));
   endtask

   task automatic test_stale_frames();
      send_frame(data_frame(next_seqno - 1, 10'd30, 1'b1));
      send_frame(data_frame('0, 10'd30, 1'b1));
      send_frame(data_frame(32'd1, LEN_EOS, 1'b1));
   endtask

   task automatic test_window_limits();
      logic [SEQ_W-1:0] base;
      base = next_seqno;
      send_frame(data_frame(base + 1, 10'd16, 1'b0));
      send_frame(data_frame(base + 2, 10'd16, 1'b0));
      send_frame(data_frame(base + 3, 10'd16, 1'b0));
      // shrink below the held count: window full
      write_window(6'd2);
      send_frame(data_frame(base, 10'd16, 1'b1));
      write_window(WINDOW_RESET);
      send_frame(data_frame(base + 8, 10'd16, 1'b1));
      // far beyond the window, bound must not wrap
      send_frame(data_frame(32'hFFFF_FFFF, 10'd16, 1'b1));
      send_frame(data_frame(base, 10'd16, 1'b1));
   endtask

   task automatic test_window_extremes();
      logic [SEQ_W-1:0] base;
      // zero window holds nothing
      write_window(6'd0);
      send_frame(data_frame(next_seqno, 10'd16, 1'b1));
      write_window(6'd1);
      send_frame(data_frame(next_seqno + 1, 10'd16, 1'b1));
      send_frame(data_frame(next_seqno, 10'd16, 1'b1));
      // oversized register clamps to the slot count
      write_window(6'd63);
      base = next_seqno;
      send_frame(data_frame(base + MAX_WINDOW, 10'd16, 1'b1));
      send_frame(data_frame(base + MAX_WINDOW - 1, 10'd16, 1'b0));
      send_frame(data_frame(base, 10'd16, 1'b1));
   endtask

   // fill the whole window backwards, then release it in one flush
   task automatic test_full_window_flush();
      int k;
      write_window(6'd32);
      for (k = MAX_WINDOW - 1; k >= 1; k--)
         send_frame(data_frame(next_seqno + k, random_length(), 1'b0));
      send_frame(data_frame(next_seqno, FRAME_W'($urandom_range(12, 400)), 1'b1));
   endtask

   task automatic run_random(input int count, input logic [WIN_W-1:0] win, input logic quiet);
      frame_type f;
      int        pick;
      int        span;
      write_window(win);
      no_idle = quiet;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 || $urandom_range(0, 19) == 0) wait_results_done();
         span = int'(window_reg);
         if (span > MAX_WINDOW) span = MAX_WINDOW;
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            // mostly in-window frames around the expected number
            f = data_frame(next_seqno + $urandom_range(0, span + 1), random_length(),
                           $urandom_range(0, 99) < 80);
         end else if (pick < 70) begin
            f = data_frame('0, random_length(), 1'b1);
         end else if (pick < 78) begin
            f = data_frame(next_seqno - $urandom_range(1, 4), random_length(), 1'b1);
         end else if (pick < 90) begin
            // broken frames
            f = data_frame(next_seqno + $urandom_range(0, span), random_length(), 1'b1);
            case ($urandom_range(0, 2))
               0: f.frame_bytes = f.frame_bytes ^ (10'd1 << $urandom_range(0, 9));
               1: f.checksum_ok = 1'b0;
               default: begin
                  f.header_length = LEN_ACK;
                  f.frame_bytes = LEN_ACK;
               end
            endcase
         end else begin
            // noise over the full field ranges
            f.frame_bytes = FRAME_W'($urandom_range(0, 1023));
            f.header_length = ($urandom_range(0, 1) != 0) ? f.frame_bytes
                                                         : FRAME_W'($urandom_range(0, 1023));
            f.checksum_ok = 1'($urandom_range(0, 1));
            f.seqno = $urandom;
            f.payload_tag = TAG_W'($urandom_range(0, 65535));
            f.output_ready = 1'($urandom_range(0, 1));
         end
         send_frame(f);
      end
      no_idle = 1'b0;
   endtask

   // compare each result with the oldest expected one
   always @(posedge clock) begin : check_results
      delivery_type want;
      if (rsp_link.valid === 1'b1 && rsp_link.ready === 1'b1) begin
         if (expected_deliveries.size() == 0) begin
            report_error("result with nothing expected");
         end else begin
            want = expected_deliveries.pop_front();
            if (rsp_link.delivered !== want.delivered)
               report_error($sformatf("delivered got %0h want %0h",
                                      rsp_link.delivered, want.delivered));
            if (rsp_link.end_of_stream !== want.end_of_stream)
               report_error($sformatf("end_of_stream got %0h want %0h",
                                      rsp_link.end_of_stream, want.end_of_stream));
            if (rsp_link.out_payload_tag !== want.out_payload_tag)
               report_error($sformatf("out_payload_tag got %0h want %0h",
                                      rsp_link.out_payload_tag, want.out_payload_tag));
            if (rsp_link.payload_bytes !== want.payload_bytes)
               report_error($sformatf("payload_bytes got %0d want %0d",
                                      rsp_link.payload_bytes, want.payload_bytes));
            if (rsp_link.ack_number !== want.ack_number)
               report_error($sformatf("ack_number got %0h want %0h",
                                      rsp_link.ack_number, want.ack_number));
            if (rsp_link.last !== want.last)
               report_error($sformatf("last got %0h want %0h", rsp_link.last, want.last));
         end
      end
   end

   // main sequence
   initial begin
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      req_link.valid <= 1'b0;
      req_link.frame_bytes <= '0;
      req_link.header_length <= '0;
      req_link.checksum_ok <= 1'b0;
      req_link.seqno <= '0;
      req_link.payload_tag <= '0;
      req_link.output_ready <= 1'b0;
      no_idle = 1'b0;
      error_count = 0;
      window_reg = WINDOW_RESET;
      next_seqno = 1;
      held_count = 0;
      for (int i = 0; i < MAX_WINDOW; i++) held_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_in_order_delivery();
      test_dropped_frames();
      test_reordering();
      test_stale_frames();
      test_window_limits();
      test_window_extremes();
      run_random(20, WINDOW_RESET, 1'b0);
      test_full_window_flush();
      run_random(14, 6'd63, 1'b1);
      run_random(14, WIN_W'($urandom_range(1, 32)), 1'b0);

      wait_results_done();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("sliding_window_receiver_test: clean");
      end else begin
         $display("sliding_window_receiver_test: errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/swr_pkg.sv
rtl/swr_req_if.sv
rtl/swr_rsp_if.sv
rtl/swr_seq_adder.sv
rtl/swr_slot_mem.sv
rtl/sliding_window_receiver.sv
test/sliding_window_receiver_test.sv
